/* rtl/jrs_pkg.sv */
// jrs_pkg: shared types, constants and the CRC-32 byte step for the journal record scanner.
// Depends on nothing; used by every file under rtl.
package jrs_pkg;

  localparam int unsigned OffsetWidth = 25;
  localparam int unsigned LimitWidth  = 24;

  localparam logic [OffsetWidth-1:0] HDR_BYTES   = 25'd24;
  localparam logic [63:0]            HDR_FIXED   = 64'h0018_0001_3831_4445;
  localparam logic [31:0]            COMMIT_WORD = 32'hC04D_17ED;
  localparam logic [31:0]            CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0]            CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0]            SAT32       = 32'hFFFF_FFFF;
  localparam logic [32:0]            FRAME_BYTES = 33'd28;
  localparam logic [LimitWidth-1:0]  LIMIT_RESET = 24'd4096;

  typedef enum logic [1:0] {
    STOP_OK      = 2'd0,
    STOP_TORN    = 2'd1,
    STOP_CORRUPT = 2'd2
  } stop_t;

  typedef struct packed {
    stop_t       scan_verdict;
    logic [31:0] intact_bytes;
    logic [31:0] intact_records;
    logic [63:0] tail_seq;
  } report_t;

  // Reflected CRC-32, one byte, bit at a time.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

/* rtl/jrs_scan_core.sv */
// jrs_scan_core: per-record parse state and scan totals; one byte step per enabled cycle.
// Depends on jrs_pkg.
module jrs_scan_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [7:0]                       data_byte,
  input  logic                             byte_present,
  input  logic                             end_of_buffer,
  input  logic [jrs_pkg::LimitWidth-1:0]   payload_limit,
  output jrs_pkg::report_t                 report
);

  logic [jrs_pkg::OffsetWidth-1:0] record_offset, record_offset_next;
  logic [31:0]                     declared_length, declared_length_next;
  logic [31:0]                     running_crc, running_crc_next;
  logic [31:0]                     stored_crc, stored_crc_next;
  logic [63:0]                     record_sequence, record_sequence_next;
  logic                            header_fault, header_fault_next;
  logic                            commit_fault, commit_fault_next;
  logic                            halted, halted_next;
  jrs_pkg::stop_t                  halt_code, halt_code_next;
  logic [31:0]                     good_bytes, good_bytes_next;
  logic [31:0]                     good_records, good_records_next;
  logic [63:0]                     newest_sequence, newest_sequence_next;

  logic [jrs_pkg::OffsetWidth-1:0] rel;
  logic [jrs_pkg::OffsetWidth-1:0] commit_pos;
  logic [1:0]                      ci;
  logic [32:0]                     byte_sum;

  assign rel        = record_offset - jrs_pkg::HDR_BYTES;
  // Length is within the limit once past the header, so 25 bits hold it.
  assign commit_pos = rel - declared_length[jrs_pkg::OffsetWidth-1:0];
  assign ci         = commit_pos[1:0];
  assign byte_sum   = {1'b0, good_bytes} + jrs_pkg::FRAME_BYTES + {1'b0, declared_length};

  always_comb begin
    record_offset_next   = record_offset;
    declared_length_next = declared_length;
    running_crc_next     = running_crc;
    stored_crc_next      = stored_crc;
    record_sequence_next = record_sequence;
    header_fault_next    = header_fault;
    commit_fault_next    = commit_fault;
    halted_next          = halted;
    halt_code_next       = halt_code;
    good_bytes_next      = good_bytes;
    good_records_next    = good_records;
    newest_sequence_next = newest_sequence;

    if (byte_present && !halted) begin
      record_offset_next = record_offset + 25'd1;
      if (record_offset < jrs_pkg::HDR_BYTES) begin
        if (record_offset < 25'd8) begin
          if (jrs_pkg::HDR_FIXED[{record_offset[2:0], 3'b000} +: 8] != data_byte) begin
            header_fault_next = 1'b1;
          end
        end else if (record_offset < 25'd16) begin
          record_sequence_next[{record_offset[2:0], 3'b000} +: 8] = data_byte;
        end else if (record_offset < 25'd20) begin
          declared_length_next[{record_offset[1:0], 3'b000} +: 8] = data_byte;
        end else begin
          stored_crc_next[{record_offset[1:0], 3'b000} +: 8] = data_byte;
        end
        // Header verdict waits for the last header byte.
        if (record_offset == jrs_pkg::HDR_BYTES - 25'd1 &&
            (header_fault_next ||
             declared_length_next > {8'd0, payload_limit})) begin
          halted_next    = 1'b1;
          halt_code_next = jrs_pkg::STOP_CORRUPT;
        end
      end else if ({7'd0, rel} < declared_length) begin
        running_crc_next = jrs_pkg::crc_byte(running_crc, data_byte);
      end else begin
        if (jrs_pkg::COMMIT_WORD[{ci, 3'b000} +: 8] != data_byte) begin
          commit_fault_next = 1'b1;
        end
        if (ci == 2'd3) begin
          if (commit_fault_next) begin
            halted_next    = 1'b1;
            halt_code_next = jrs_pkg::STOP_TORN;
          end else if (~running_crc != stored_crc) begin
            halted_next    = 1'b1;
            halt_code_next = jrs_pkg::STOP_CORRUPT;
          end else begin
            good_bytes_next      = byte_sum[32] ? jrs_pkg::SAT32 : byte_sum[31:0];
            good_records_next    = (good_records == jrs_pkg::SAT32) ?
                                   good_records : good_records + 32'd1;
            newest_sequence_next = record_sequence;
            record_offset_next   = '0;
            declared_length_next = '0;
            running_crc_next     = jrs_pkg::CRC_INIT;
            stored_crc_next      = '0;
            record_sequence_next = '0;
            header_fault_next    = 1'b0;
            commit_fault_next    = 1'b0;
          end
        end
      end
    end

    // Report reflects this item's byte, if any.
    if (halted_next) begin
      report.scan_verdict = halt_code_next;
    end else if (record_offset_next != '0) begin
      report.scan_verdict = jrs_pkg::STOP_TORN;
    end else begin
      report.scan_verdict = jrs_pkg::STOP_OK;
    end
    report.intact_bytes   = good_bytes_next;
    report.intact_records = good_records_next;
    report.tail_seq       = newest_sequence_next;

    if (end_of_buffer) begin
      record_offset_next   = '0;
      declared_length_next = '0;
      running_crc_next     = jrs_pkg::CRC_INIT;
      stored_crc_next      = '0;
      record_sequence_next = '0;
      header_fault_next    = 1'b0;
      commit_fault_next    = 1'b0;
      halted_next          = 1'b0;
      halt_code_next       = jrs_pkg::STOP_OK;
      good_bytes_next      = '0;
      good_records_next    = '0;
      newest_sequence_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_offset   <= '0;
      declared_length <= '0;
      running_crc     <= jrs_pkg::CRC_INIT;
      stored_crc      <= '0;
      record_sequence <= '0;
      header_fault    <= 1'b0;
      commit_fault    <= 1'b0;
      halted          <= 1'b0;
      halt_code       <= jrs_pkg::STOP_OK;
      good_bytes      <= '0;
      good_records    <= '0;
      newest_sequence <= '0;
    end else if (step) begin
      record_offset   <= record_offset_next;
      declared_length <= declared_length_next;
      running_crc     <= running_crc_next;
      stored_crc      <= stored_crc_next;
      record_sequence <= record_sequence_next;
      header_fault    <= header_fault_next;
      commit_fault    <= commit_fault_next;
      halted          <= halted_next;
      halt_code       <= halt_code_next;
      good_bytes      <= good_bytes_next;
      good_records    <= good_records_next;
      newest_sequence <= newest_sequence_next;
    end
  end

endmodule

/* rtl/journal_record_scanner.sv */
// journal_record_scanner: top level; input item register, scan core, report output register.
// Depends on jrs_pkg and jrs_scan_core.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   in      | sink      | in_valid/in_ready  | data_byte, byte_present, end_of_buffer
//   out     | source    | out_valid/out_ready| scan_verdict, intact_bytes, intact_records,
//           |           |                    | tail_seq
//   cfg     | sink      | cfg_we (no wait)   | cfg_wdata = payload_limit
//
// One item per cycle, unless an end_of_buffer item waits on a report not yet taken. An item
// sits in the input register, where the byte-wide CRC step and the header/commit compares run;
// its report (end_of_buffer items only) is then registered in the output register, which
// drives out_valid. Synchronous reset clears all scan state and sets payload_limit to 4096.
// A report not yet taken holds the output register; only an end_of_buffer item then waits
// in the input register, and in_ready drops until the report is taken.
module journal_record_scanner (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           byte_present,
  input  logic                           end_of_buffer,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     scan_verdict,
  output logic [31:0]                    intact_bytes,
  output logic [31:0]                    intact_records,
  output logic [63:0]                    tail_seq,
  input  logic                           cfg_we,
  input  logic [jrs_pkg::LimitWidth-1:0] cfg_wdata
);

  logic [jrs_pkg::LimitWidth-1:0] payload_limit;

  // Input item register.
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_present;
  logic       in_last;

  logic             out_free;
  logic             step;
  jrs_pkg::report_t report;
  jrs_pkg::report_t out_report;

  assign out_free = !out_valid || out_ready;
  // A non-final item never needs the output slot.
  assign step     = in_full && (!in_last || out_free);
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= jrs_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      payload_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte    <= data_byte;
      in_present <= byte_present;
      in_last    <= end_of_buffer;
    end
  end

  jrs_scan_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (in_byte),
    .byte_present  (in_present),
    .end_of_buffer (in_last),
    .payload_limit (payload_limit),
    .report        (report)
  );

  // Report register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && in_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      out_report <= report;
    end
  end

  assign scan_verdict   = out_report.scan_verdict;
  assign intact_bytes   = out_report.intact_bytes;
  assign intact_records = out_report.intact_records;
  assign tail_seq       = out_report.tail_seq;

endmodule

/* rtl/jrs_checker.sv */
// jrs_checker: port-level assertions for journal_record_scanner, bound to the top level.
// Depends on jrs_pkg and journal_record_scanner.
module jrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  scan_verdict,
  input logic [31:0] intact_bytes,
  input logic [31:0] intact_records,
  input logic [63:0] tail_seq
);

  // Stalled report holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scan_verdict) &&
      $stable(intact_bytes) && $stable(intact_records) && $stable(tail_seq))
    else $error("report changed while stalled");

  a_reason_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (scan_verdict == jrs_pkg::STOP_OK || scan_verdict == jrs_pkg::STOP_TORN ||
                   scan_verdict == jrs_pkg::STOP_CORRUPT))
    else $error("undefined stop reason");

  a_no_records: assert property (@(posedge clk) disable iff (rst)
    out_valid && intact_records == 32'd0 |-> intact_bytes == 32'd0 && tail_seq == 64'd0)
    else $error("totals without any valid record");

  // Every record is at least header plus commit word long.
  a_min_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && intact_records != 32'd0 |-> intact_bytes >= 32'd28)
    else $error("byte total too small for record count");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("report valid right after reset");

endmodule

bind journal_record_scanner jrs_checker u_jrs_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .scan_verdict   (scan_verdict),
  .intact_bytes   (intact_bytes),
  .intact_records (intact_records),
  .tail_seq       (tail_seq)
);
